// ----- rtl/hhc_pkg.sv -----
// Shared constants and types for the high-pass, hold and crush audio effect.
package hhc_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COEF_BITS       = 16;
  localparam int CFG_DATA_BITS   = COEF_BITS + 1;
  localparam int HOLD_BITS       = 8;
  localparam int CRUSH_REG_BITS  = 5;
  localparam int CFG_INDEX_BITS  = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLE      = 2'd0,
    REG_HP_COEF     = 2'd1,
    REG_HOLD_FACTOR = 2'd2,
    REG_CRUSH_BITS  = 2'd3
  } cfg_reg_t;

endpackage

// ----- rtl/highpass_hold_crush_effect.sv -----
// An accepted sample passes the input, filter and hold/crush registers to the master side.
// Throughput: one sample per cycle while m_tready holds; the filter feedback closes in
// the filter stage (split coefficient multiply), hold and crush sit in the following stage.
// Three registered stages (input, filter, hold/crush) each advance when the next one frees.
// Reset (rst, synchronous): config to enable 0, hp_coef 0, hold_factor 1, crush_bits 0;
// filter and hold state cleared to zero; all stages empty.
module highpass_hold_crush_effect
  import hhc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((SAMPLE_BITS+2+7)/8)*8-1:0]   m_tdata,   // processed
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]            cfg_index,
  input  logic [CFG_DATA_BITS-1:0]             cfg_data
);

  localparam int O      = SAMPLE_BITS + 2;
  localparam int Y      = SAMPLE_BITS + 2 + FRAC_BITS;
  localparam int HI_W   = Y + 1 - COEF_BITS;
  localparam int PH_W   = HI_W + COEF_BITS + 2;
  localparam int LO_W   = 2 * COEF_BITS + 2;
  localparam int OUT_TW = ((O + 7) / 8) * 8;
  localparam int KW     = $clog2(SAMPLE_BITS + FRAC_BITS + 1);
  localparam int CW     = $clog2(SAMPLE_BITS + 1);

  // configuration
  logic                      enable;
  logic [CFG_DATA_BITS-1:0]  hp_coef;
  logic [HOLD_BITS-1:0]      hold_factor;
  logic [CRUSH_REG_BITS-1:0] crush_bits;

  // effect state
  logic signed [SAMPLE_BITS-1:0] prev_input;
  logic signed [Y-1:0]           prev_filtered;
  logic [HOLD_BITS-1:0]          hold_count;
  logic signed [O-1:0]           held_value;

  // pipeline registers
  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_x;
  logic                          mid_valid;
  logic signed [Y-1:0]           mid_v;
  logic                          out_valid;
  logic signed [O-1:0]           out_value;

  logic ready_out, ready_mid, ready_in;
  logic mid_load, out_load;

  logic [CFG_DATA_BITS-1:0] a_eff;
  logic [CW-1:0]            c_eff;
  logic [KW-1:0]            k;
  logic                     filt_on, hold_on, crush_on, bypass;

  logic signed [SAMPLE_BITS:0] diff;
  logic signed [Y:0]           sum;
  logic signed [HI_W-1:0]      hi;
  logic [COEF_BITS-1:0]        lo;
  logic signed [PH_W-1:0]      prod_hi;
  logic [LO_W-1:0]             lo_sum;
  logic signed [PH_W-1:0]      y_full;
  logic signed [Y-1:0]         y_sat;
  logic signed [Y-1:0]         v_filt;

  logic signed [O-1:0]   v_int;
  logic signed [O-1:0]   held_next;
  logic [HOLD_BITS-1:0]  hold_count_next;
  logic signed [Y-1:0]   v_hold;
  logic signed [Y:0]     v_ext;
  logic signed [Y:0]     v_round;
  logic [Y:0]            crush_mask;
  logic signed [Y:0]     v_crush;
  logic signed [O:0]     q;
  logic signed [O-1:0]   processed_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      hp_coef     <= '0;
      hold_factor <= HOLD_BITS'(1);
      crush_bits  <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:      enable      <= cfg_data[0];
        REG_HP_COEF:     hp_coef     <= cfg_data;
        REG_HOLD_FACTOR: hold_factor <= cfg_data[HOLD_BITS-1:0];
        REG_CRUSH_BITS:  crush_bits  <= cfg_data[CRUSH_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage control
  assign ready_out = !out_valid || m_tready;
  assign ready_mid = !mid_valid || ready_out;
  assign ready_in  = !in_valid || ready_mid;
  assign s_tready  = ready_in;
  assign mid_load  = in_valid && ready_mid;
  assign out_load  = mid_valid && ready_out;

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TW'($unsigned(out_value));

  // effective settings
  always_comb begin
    a_eff    = (hp_coef > CFG_DATA_BITS'(1 << COEF_BITS)) ? CFG_DATA_BITS'(1 << COEF_BITS)
                                                          : hp_coef;
    c_eff    = (crush_bits > CRUSH_REG_BITS'(SAMPLE_BITS)) ? CW'(SAMPLE_BITS)
                                                           : CW'(crush_bits);
    k        = KW'(SAMPLE_BITS + FRAC_BITS) - KW'(c_eff);
    bypass   = !enable || (a_eff == '0 && hold_factor <= HOLD_BITS'(1) && c_eff == '0);
    filt_on  = !bypass && (a_eff != '0);
    hold_on  = !bypass && (hold_factor > HOLD_BITS'(1));
    crush_on = !bypass && (c_eff != '0);
  end

  // filter stage
  always_comb begin
    diff    = {in_x[SAMPLE_BITS-1], in_x} - {prev_input[SAMPLE_BITS-1], prev_input};
    sum     = {prev_filtered[Y-1], prev_filtered} + ((Y+1)'(diff) <<< FRAC_BITS);
    hi      = sum[Y:COEF_BITS];
    lo      = sum[COEF_BITS-1:0];
    prod_hi = PH_W'($signed({1'b0, a_eff})) * PH_W'(hi);
    lo_sum  = LO_W'(a_eff) * LO_W'(lo) + LO_W'(1 << (COEF_BITS - 1));
    y_full  = prod_hi + PH_W'($signed({1'b0, lo_sum[LO_W-1:COEF_BITS]}));
    if (y_full[PH_W-1:Y-1] != {(PH_W-Y+1){y_full[PH_W-1]}}) begin
      y_sat = y_full[PH_W-1] ? {1'b1, {(Y-1){1'b0}}} : {1'b0, {(Y-1){1'b1}}};
    end else begin
      y_sat = y_full[Y-1:0];
    end
    v_filt = filt_on ? y_sat : (Y'(in_x) <<< FRAC_BITS);
  end

  // hold and crush stage
  always_comb begin
    v_int = mid_v[Y-1:FRAC_BITS] + O'(mid_v[Y-1] && (|mid_v[FRAC_BITS-1:0]));
    held_next = (hold_count == '0) ? v_int : held_value;
    hold_count_next = ((HOLD_BITS+1)'(hold_count) + (HOLD_BITS+1)'(1) >=
                       (HOLD_BITS+1)'(hold_factor)) ? '0 : hold_count + HOLD_BITS'(1);
    v_hold = hold_on ? {held_next, {FRAC_BITS{1'b0}}} : mid_v;
    v_ext = {v_hold[Y-1], v_hold};
    v_round = v_ext + ((Y+1)'(1) << (k - KW'(1)));
    crush_mask = {(Y+1){1'b1}} << k;
    v_crush = crush_on ? (v_round & crush_mask) : v_ext;
    q = v_crush[Y:FRAC_BITS] + (O+1)'(v_crush[Y] && (|v_crush[FRAC_BITS-1:0]));
    if (q[O] != q[O-1]) begin
      processed_next = q[O] ? {1'b1, {(O-1){1'b0}}} : {1'b0, {(O-1){1'b1}}};
    end else begin
      processed_next = q[O-1:0];
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      mid_valid     <= 1'b0;
      out_valid     <= 1'b0;
      prev_input    <= '0;
      prev_filtered <= '0;
      hold_count    <= '0;
      held_value    <= '0;
    end else begin
      if (ready_in) begin
        in_valid <= s_tvalid;
      end
      if (ready_mid) begin
        mid_valid <= in_valid;
      end
      if (ready_out) begin
        out_valid <= mid_valid;
      end
      if (mid_load && filt_on) begin
        prev_input    <= in_x;
        prev_filtered <= y_sat;
      end
      if (out_load && hold_on) begin
        held_value <= held_next;
        hold_count <= hold_count_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ready_in && s_tvalid) begin
      in_x <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (mid_load) begin
      mid_v <= v_filt;
    end
    if (out_load) begin
      out_value <= processed_next;
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the high-pass, hold and crush audio effect.
module testbench;
  import hhc_pkg::*;

  localparam int SAMPLE_W    = SAMPLE_BITS_DEF;
  localparam int FRAC_W      = FRAC_BITS_DEF;
  localparam int OUT_W       = SAMPLE_W + 2;
  localparam int ACC_W       = SAMPLE_W + 2 + FRAC_W;
  localparam int S_W         = ((SAMPLE_W + 7) / 8) * 8;
  localparam int M_W         = ((OUT_W + 7) / 8) * 8;
  localparam longint UNITY   = 64'sd1 <<< COEF_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 75;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [S_W-1:0]           s_tdata = '0;   // sample
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [M_W-1:0]           m_tdata;        // processed
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  cfg_reg_t                 cfg_index = REG_ENABLE;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // register mirror and filter/hold state of the predictor
  bit     mir_enable = 1'b0;
  int     mir_coef   = 0;
  int     mir_hold   = 1;
  int     mir_crush  = 0;
  longint in_prev    = 0;
  longint filt_prev  = 0;
  int     hold_pos   = 0;
  longint held       = 0;

  logic [SAMPLE_W-1:0] pending_samples[$];
  logic [OUT_W-1:0]    processed_due[$];
  logic [OUT_W-1:0]    due;
  int issued = 0;
  int accepted = 0;
  int mismatch_cnt = 0;
  int cycles = 0;
  int gap_left = 0;
  int src_quiet = 0;
  int stall_left = 0;
  int sink_quiet = 0;

  highpass_hold_crush_effect u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint trunc_frac(input longint v);
    return (v >= 0) ? (v >>> FRAC_W) : -((-v) >>> FRAC_W);
  endfunction

  function automatic logic [OUT_W-1:0] predict_processed(input logic [SAMPLE_W-1:0] raw);
    longint x;
    longint a;
    longint c;
    longint v;
    longint sum;
    longint hi;
    longint lo;
    longint y;
    int k;
    x = longint'($signed(raw));
    a = (mir_coef > UNITY) ? UNITY : longint'(mir_coef);
    c = (mir_crush > SAMPLE_W) ? SAMPLE_W : mir_crush;
    if (!mir_enable || (a == 0 && mir_hold <= 1 && c == 0)) return OUT_W'(x);
    v = x <<< FRAC_W;
    if (a > 0) begin
      sum = filt_prev + ((x - in_prev) <<< FRAC_W);
      hi = sum >>> COEF_BITS;
      lo = sum - (hi <<< COEF_BITS);
      y = a * hi + ((a * lo + (64'sd1 <<< (COEF_BITS - 1))) >>> COEF_BITS);
      y = clamp(y, ACC_W);
      in_prev = x;
      filt_prev = y;
      v = y;
    end
    if (mir_hold > 1) begin
      if (hold_pos == 0) held = clamp(trunc_frac(v), OUT_W);
      hold_pos = (hold_pos + 1 >= mir_hold) ? 0 : hold_pos + 1;
      v = held <<< FRAC_W;
    end
    if (c > 0) begin
      k = SAMPLE_W - int'(c) + FRAC_W;
      v = ((v + (64'sd1 <<< (k - 1))) >>> k) <<< k;
    end
    return OUT_W'(clamp(trunc_frac(v), OUT_W));
  endfunction

  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        processed_due.push_back(predict_processed(s_tdata[SAMPLE_W-1:0]));
        accepted++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= S_W'(pending_samples.pop_front());
          gap_left = draw_wait(src_quiet);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (processed_due.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %h", $time, m_tdata);
          mismatch_cnt++;
        end else begin
          due = processed_due.pop_front();
          if (m_tdata !== M_W'(due)) begin
            $display("%0t: processed mismatch, expected %h, actual %h", $time, M_W'(due),
                     m_tdata);
            mismatch_cnt++;
          end
        end
        stall_left = draw_wait(sink_quiet);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic queue_sample(input int v);
    pending_samples.push_back(SAMPLE_W'(v));
    issued++;
  endtask

  task automatic wait_drained();
    while (!(accepted == issued && processed_due.size() == 0)) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENABLE:      mir_enable = val[0];
      REG_HP_COEF:     mir_coef = val & 32'h1FFFF;
      REG_HOLD_FACTOR: mir_hold = val & 32'hFF;
      REG_CRUSH_BITS:  mir_crush = val & 32'h1F;
      default: ;
    endcase
  endtask

  function automatic int with_noise(input int val, input int keep_mask);
    if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 131071) & ~keep_mask) | val;
    return val;
  endfunction

  function automatic int draw_sample();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 255)) - 128;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  initial begin
    int coef;
    int hold;
    int crush;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled: pass through
    queue_sample(-32768);
    queue_sample(32767);
    queue_sample(0);
    queue_sample(-1);
    wait_drained();

    // enabled with every stage off
    write_reg(REG_ENABLE, 1);
    queue_sample(32767);
    queue_sample(-32768);
    wait_drained();

    write_reg(REG_HP_COEF, 65536);
    queue_sample(32767);
    queue_sample(-32768);
    queue_sample(32767);
    queue_sample(-32768);
    wait_drained();

    // coefficient above one
    write_reg(REG_HP_COEF, 131071);
    queue_sample(-32768);
    queue_sample(32767);
    wait_drained();

    // crush above resolution, then coarsest crush
    write_reg(REG_HP_COEF, 0);
    write_reg(REG_CRUSH_BITS, 17);
    queue_sample(12345);
    queue_sample(-12345);
    wait_drained();
    write_reg(REG_CRUSH_BITS, 1);
    queue_sample(16384);
    queue_sample(-16385);
    wait_drained();

    // hold factor zero
    write_reg(REG_CRUSH_BITS, 0);
    write_reg(REG_HOLD_FACTOR, 0);
    queue_sample(100);
    queue_sample(-100);
    wait_drained();

    // lower the factor below the running count
    write_reg(REG_HOLD_FACTOR, 200);
    queue_sample(-20000);
    queue_sample(5);
    queue_sample(6);
    queue_sample(7);
    wait_drained();
    write_reg(REG_HOLD_FACTOR, 3);
    queue_sample(-7);
    queue_sample(31000);
    queue_sample(-31000);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 6))
        0: coef = 0;
        1: coef = 65536;
        2: coef = $urandom_range(65537, 131071);
        3: coef = $urandom_range(60000, 65535);
        4: coef = 65535;
        5: coef = 1;
        default: coef = $urandom_range(0, 131071);
      endcase
      case ($urandom_range(0, 5))
        0: hold = 0;
        1: hold = 1;
        2: hold = 2;
        3: hold = 255;
        4: hold = $urandom_range(2, 8);
        default: hold = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 5))
        0: crush = 0;
        1: crush = 16;
        2: crush = $urandom_range(17, 31);
        3: crush = 1;
        4: crush = $urandom_range(1, 15);
        default: crush = $urandom_range(0, 31);
      endcase
      write_reg(REG_ENABLE, with_noise(($urandom_range(0, 7) != 0) ? 1 : 0, 32'h1));
      write_reg(REG_HP_COEF, coef);
      write_reg(REG_HOLD_FACTOR, with_noise(hold, 32'hFF));
      write_reg(REG_CRUSH_BITS, with_noise(crush, 32'h1F));
      for (int i = 0; i < PHASE_ITEMS; i++) queue_sample(draw_sample());
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
